### design/tfpf_pkg.sv
`default_nettype none
package tfpf_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 24;

  typedef logic signed [DATA_WIDTH-1:0] fx_t;

  localparam fx_t FX_MAX = fx_t'({1'b0, {(DATA_WIDTH-1){1'b1}}});
  localparam fx_t FX_MIN = fx_t'({1'b1, {(DATA_WIDTH-1){1'b0}}});
  localparam fx_t FX_ONE_LSB = fx_t'(1);

  // register indexes
  localparam logic [2:0] REG_TIME_STEP  = 3'd0;
  localparam logic [2:0] REG_CAPILLARY  = 3'd1;
  localparam logic [2:0] REG_STABILIZER = 3'd2;
  localparam logic [2:0] REG_GRAVITY    = 3'd3;
  localparam logic [2:0] REG_SLIP       = 3'd4;
  localparam logic [2:0] REG_CELL_SIZE  = 3'd5;

  localparam logic [30:0] RST_TIME_STEP  = 31'd16777;
  localparam logic [30:0] RST_CAPILLARY  = 31'd167772;
  localparam logic [30:0] RST_STABILIZER = 31'd83886;
  localparam logic [30:0] RST_GRAVITY    = 31'd83886080;
  localparam logic [30:0] RST_SLIP       = 31'd0;
  localparam logic [24:0] RST_CELL_SIZE  = 25'd32768;

  localparam logic [63:0] RECIP6 = 64'hAAAAAAAB;

  // divider pipeline shape
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES = DATA_WIDTH / DIV_BITS_PER_STAGE;
  localparam int DIV_NW = DATA_WIDTH + FRAC_BITS + 1;

  typedef logic signed [39:0] wide_t;

  function automatic fx_t clip40(input wide_t v);
    if (v > 40'sh007FFFFFFF) return FX_MAX;
    if (v < -40'sh0080000000) return FX_MIN;
    return fx_t'(v[31:0]);
  endfunction

  function automatic fx_t sadd(input fx_t a, input fx_t b);
    return clip40(wide_t'(a) + wide_t'(b));
  endfunction

  function automatic fx_t sneg(input fx_t a);
    return (a == FX_MIN) ? FX_MAX : -a;
  endfunction

  function automatic fx_t ssub(input fx_t a, input fx_t b);
    return sadd(a, sneg(b));
  endfunction

  function automatic fx_t scale(input fx_t a, input logic [3:0] k);
    return clip40(wide_t'(a) * wide_t'(signed'({1'b0, k})));
  endfunction

  function automatic logic [31:0] magn(input fx_t a);
    return a[31] ? (~a + 32'd1) : a;
  endfunction

  function automatic fx_t satmag(input logic neg, input logic [40:0] m);
    if (m > 41'h07FFFFFFF) return neg ? FX_MIN : FX_MAX;
    return neg ? -fx_t'(m[31:0]) : fx_t'(m[31:0]);
  endfunction

  // product rounded to nearest, ties away from zero
  function automatic fx_t fmul(input fx_t a, input fx_t b);
    logic        neg;
    logic [64:0] p;
    neg = a[31] ^ b[31];
    p = 65'(magn(a)) * 65'(magn(b)) + (65'(1) << (FRAC_BITS - 1));
    return satmag(neg, 41'(p >> FRAC_BITS));
  endfunction

  function automatic fx_t idiv6(input logic [30:0] v);
    logic [31:0] x;
    logic [63:0] p;
    x = {1'b0, v} + 32'd3;
    p = 64'(x) * RECIP6;
    return fx_t'({2'b00, p[63:34]});
  endfunction

  function automatic fx_t idiv2(input logic [30:0] v);
    logic [31:0] x;
    x = {1'b0, v} + 32'd1;
    return fx_t'({1'b0, x[31:1]});
  endfunction

endpackage
`default_nettype wire

### design/tfpf_div.sv
`default_nettype none
module tfpf_div #(
  parameter int SIDE_W = 1
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire tfpf_pkg::fx_t      num,
  input  wire tfpf_pkg::fx_t      den,
  input  wire logic [SIDE_W-1:0]  side_in,
  output logic                    out_valid,
  output tfpf_pkg::fx_t           quo,
  output logic [SIDE_W-1:0]       side_out
);

  localparam int NS  = tfpf_pkg::DIV_STAGES;
  localparam int BPS = tfpf_pkg::DIV_BITS_PER_STAGE;
  localparam int NW  = tfpf_pkg::DIV_NW;

  logic [31:0]   ma;
  logic [31:0]   mb;
  logic [NW-1:0] n_in;
  logic          ovf_in;

  assign ma = tfpf_pkg::magn(num);
  assign mb = tfpf_pkg::magn(den);
  assign n_in = (NW'(ma) << tfpf_pkg::FRAC_BITS) + NW'(mb >> 1);
  assign ovf_in = 64'(n_in) >= (64'(mb) << 31);

  logic [32:0]       rem  [NS+1];
  logic [31:0]       lo   [NS+1];
  logic [31:0]       qt   [NS+1];
  logic [31:0]       dv   [NS+1];
  logic              neg  [NS+1];
  logic              zro  [NS+1];
  logic              ovf  [NS+1];
  logic              vld  [NS+1];
  logic [SIDE_W-1:0] sd   [NS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= 33'(n_in >> 32);
      lo[0]  <= n_in[31:0];
      qt[0]  <= '0;
      dv[0]  <= mb;
      neg[0] <= num[31] ^ den[31];
      zro[0] <= (ma == '0);
      ovf[0] <= ovf_in;
      sd[0]  <= side_in;
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [32:0] r_n;
    logic [31:0] l_n;
    logic [31:0] q_n;

    always_comb begin
      r_n = rem[s];
      l_n = lo[s];
      q_n = qt[s];
      for (int k = 0; k < BPS; k++) begin
        r_n = {r_n[31:0], l_n[31]};
        l_n = {l_n[30:0], 1'b0};
        if (r_n >= {1'b0, dv[s]}) begin
          r_n = r_n - {1'b0, dv[s]};
          q_n = {q_n[30:0], 1'b1};
        end else begin
          q_n = {q_n[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= r_n;
        lo[s+1]  <= l_n;
        qt[s+1]  <= q_n;
        dv[s+1]  <= dv[s];
        neg[s+1] <= neg[s];
        zro[s+1] <= zro[s];
        ovf[s+1] <= ovf[s];
        sd[s+1]  <= sd[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= sd[NS];
      if (zro[NS]) begin
        quo <= '0;
      end else if (ovf[NS]) begin
        quo <= neg[NS] ? tfpf_pkg::FX_MIN : tfpf_pkg::FX_MAX;
      end else begin
        quo <= neg[NS] ? -tfpf_pkg::fx_t'(qt[NS]) : tfpf_pkg::fx_t'(qt[NS]);
      end
    end
  end

endmodule
`default_nettype wire

### design/thin_film_pair_flux.sv
// Film exchange between two neighboring cells. One item per clock cycle is taken
// in unless the output stalls. Each item passes four arithmetic stages, a
// rounding divider of 18 stages for the mobility quotient, four stages, a second
// divider for M*h/theta, two stages, a third divider for tau*f/h and the output
// register. The dividers resolve two quotient bits per stage. The whole pipeline
// holds while a result waits at the output, so s_tready drops only then. The user
// writes configuration while the pipeline is empty; the block does not enforce it.
`default_nettype none
module thin_film_pair_flux (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // thick_p, thick_q, lap_sum_p, lap_sum_q, surf_p, surf_q, curv_p, curv_q,
  // cos_p, cos_q, edge_term, zero pad
  input  wire logic [343:0] s_tdata,
  // vertical
  input  wire logic [0:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // transfer, new_thick_q, new_thick_p, zero pad
  output logic [95:0]       m_tdata,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [30:0]  cfg_data
);

  typedef tfpf_pkg::fx_t fx_t;

  logic [30:0] tau;
  logic [30:0] cap;
  logic [30:0] stab;
  logic [30:0] grav;
  logic [30:0] slip;
  logic [24:0] csize;

  always_ff @(posedge clk) begin
    if (rst) begin
      tau   <= tfpf_pkg::RST_TIME_STEP;
      cap   <= tfpf_pkg::RST_CAPILLARY;
      stab  <= tfpf_pkg::RST_STABILIZER;
      grav  <= tfpf_pkg::RST_GRAVITY;
      slip  <= tfpf_pkg::RST_SLIP;
      csize <= tfpf_pkg::RST_CELL_SIZE;
    end else if (cfg_we) begin
      case (cfg_index)
        tfpf_pkg::REG_TIME_STEP:  tau   <= cfg_data;
        tfpf_pkg::REG_CAPILLARY:  cap   <= cfg_data;
        tfpf_pkg::REG_STABILIZER: stab  <= cfg_data;
        tfpf_pkg::REG_GRAVITY:    grav  <= cfg_data;
        tfpf_pkg::REG_SLIP:       slip  <= cfg_data;
        tfpf_pkg::REG_CELL_SIZE:  csize <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  fx_t tau_x, e_x, eta_x, g_x, h_x;
  assign tau_x = fx_t'({1'b0, tau});
  assign e_x   = fx_t'({1'b0, cap});
  assign eta_x = fx_t'({1'b0, stab});
  assign g_x   = fx_t'({1'b0, grav});
  assign h_x   = fx_t'({7'd0, csize});

  fx_t up, uq, lp, lq, sp, sq, tp, tq, cp, cq, edge_in;
  assign up      = fx_t'({1'b0, s_tdata[30:0]});
  assign uq      = fx_t'({1'b0, s_tdata[61:31]});
  assign lp      = fx_t'(s_tdata[93:62]);
  assign lq      = fx_t'(s_tdata[125:94]);
  assign sp      = fx_t'(s_tdata[157:126]);
  assign sq      = fx_t'(s_tdata[189:158]);
  assign tp      = fx_t'(s_tdata[221:190]);
  assign tq      = fx_t'(s_tdata[253:222]);
  assign cp      = fx_t'(signed'(s_tdata[279:254]));
  assign cq      = fx_t'(signed'(s_tdata[305:280]));
  assign edge_in = fx_t'(s_tdata[337:306]);

  logic en;
  logic r11_v;
  assign en = !r11_v || m_tready;
  assign s_tready = en;

  // stage 1
  logic r1_v, r1_vert;
  fx_t r1_p2, r1_q2, r1_den, r1_ge, r1_gh, r1_hh, r1_gcq, r1_gcp, r1_csum, r1_tsum;
  fx_t r1_sdiff, r1_dq, r1_dl, r1_e5eta, r1_a0, r1_e6, r1_b2;
  fx_t r1_up, r1_uq, r1_tp, r1_tq, r1_edge;
  // stage 2
  logic r2_v;
  fx_t r2_pq, r2_t3, r2_gec, r2_et, r2_b1, r2_el, r2_wd, r2_x, r2_y;
  fx_t r2_den, r2_hh, r2_e6, r2_edge, r2_a0, r2_up, r2_uq;
  // stage 3
  logic r3_v;
  fx_t r3_pq2, r3_t2a, r3_a1, r3_bb, r3_exy, r3_den, r3_hh, r3_t3, r3_edge, r3_up, r3_uq;
  // stage 4
  logic r4_v;
  fx_t r4_t2, r4_b, r4_pq2, r4_den, r4_t3, r4_a1, r4_hh, r4_up, r4_uq;

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_v <= 1'b0;
      r2_v <= 1'b0;
      r3_v <= 1'b0;
      r4_v <= 1'b0;
    end else if (en) begin
      r1_v <= s_tvalid;
      r2_v <= r1_v;
      r3_v <= r2_v;
      r4_v <= r3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_p2    <= tfpf_pkg::fmul(up, up);
      r1_q2    <= tfpf_pkg::fmul(uq, uq);
      r1_den   <= tfpf_pkg::scale(tfpf_pkg::sadd(uq, up), 4'd3);
      r1_ge    <= tfpf_pkg::fmul(g_x, e_x);
      r1_gh    <= tfpf_pkg::fmul(g_x, h_x);
      r1_hh    <= tfpf_pkg::fmul(h_x, h_x);
      r1_gcq   <= tfpf_pkg::fmul(g_x, cq);
      r1_gcp   <= tfpf_pkg::fmul(g_x, cp);
      r1_csum  <= tfpf_pkg::sadd(cp, cq);
      r1_tsum  <= tfpf_pkg::sadd(tp, tq);
      r1_sdiff <= tfpf_pkg::ssub(sp, sq);
      r1_dq    <= tfpf_pkg::ssub(uq, up);
      r1_dl    <= tfpf_pkg::ssub(lq, lp);
      r1_e5eta <= tfpf_pkg::sadd(tfpf_pkg::scale(e_x, 4'd5), eta_x);
      r1_a0    <= tfpf_pkg::sadd(tfpf_pkg::scale(e_x, 4'd8), tfpf_pkg::scale(eta_x, 4'd2));
      r1_e6    <= tfpf_pkg::idiv6(cap);
      r1_b2    <= tfpf_pkg::idiv2(slip);
      r1_up    <= up;
      r1_uq    <= uq;
      r1_tp    <= tp;
      r1_tq    <= tq;
      r1_edge  <= edge_in;
      r1_vert  <= s_tuser[0];

      r2_pq   <= tfpf_pkg::fmul(r1_p2, r1_q2);
      r2_t3   <= tfpf_pkg::fmul(r1_b2, tfpf_pkg::sadd(r1_p2, r1_q2));
      r2_gec  <= tfpf_pkg::fmul(r1_ge, r1_csum);
      r2_et   <= tfpf_pkg::fmul(e_x, r1_tsum);
      r2_b1   <= tfpf_pkg::fmul(r1_e5eta, r1_dq);
      r2_el   <= tfpf_pkg::fmul(e_x, r1_dl);
      r2_wd   <= tfpf_pkg::sadd(r1_vert ? tfpf_pkg::sneg(r1_gh) : '0, r1_sdiff);
      r2_x    <= tfpf_pkg::fmul(tfpf_pkg::ssub(r1_gcq, r1_tq), r1_uq);
      r2_y    <= tfpf_pkg::fmul(tfpf_pkg::ssub(r1_gcp, r1_tp), r1_up);
      r2_den  <= r1_den;
      r2_hh   <= r1_hh;
      r2_e6   <= r1_e6;
      r2_edge <= r1_edge;
      r2_a0   <= r1_a0;
      r2_up   <= r1_up;
      r2_uq   <= r1_uq;

      r3_pq2  <= tfpf_pkg::scale(r2_pq, 4'd2);
      r3_t2a  <= tfpf_pkg::fmul(r2_e6, r2_pq);
      r3_a1   <= tfpf_pkg::ssub(tfpf_pkg::sadd(r2_a0, r2_gec), r2_et);
      r3_bb   <= tfpf_pkg::sadd(tfpf_pkg::ssub(r2_b1, r2_el), r2_wd);
      r3_exy  <= tfpf_pkg::fmul(e_x, tfpf_pkg::ssub(r2_x, r2_y));
      r3_den  <= r2_den;
      r3_hh   <= r2_hh;
      r3_t3   <= r2_t3;
      r3_edge <= r2_edge;
      r3_up   <= r2_up;
      r3_uq   <= r2_uq;

      r4_t2  <= tfpf_pkg::fmul(r3_t2a, r3_edge);
      r4_b   <= tfpf_pkg::sadd(r3_bb, r3_exy);
      r4_pq2 <= r3_pq2;
      r4_den <= r3_den;
      r4_t3  <= r3_t3;
      r4_a1  <= r3_a1;
      r4_hh  <= r3_hh;
      r4_up  <= r3_up;
      r4_uq  <= r3_uq;
    end
  end

  localparam int SIDE1_W = 1 + 7 * tfpf_pkg::DATA_WIDTH;
  logic               d1_v;
  fx_t                d1_q;
  logic [SIDE1_W-1:0] d1_side;
  logic               d1_dz;
  fx_t d1_t2, d1_t3, d1_a1, d1_b, d1_hh, d1_up, d1_uq;

  tfpf_div #(.SIDE_W(SIDE1_W)) u_div_mob (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (r4_v),
    .num      (r4_pq2),
    .den      (r4_den),
    .side_in  ({r4_den == '0, r4_t2, r4_t3, r4_a1, r4_b, r4_hh, r4_up, r4_uq}),
    .out_valid(d1_v),
    .quo      (d1_q),
    .side_out (d1_side)
  );

  assign {d1_dz, d1_t2, d1_t3, d1_a1, d1_b, d1_hh, d1_up, d1_uq} = d1_side;

  // stages 5 to 8
  logic r5_v, r6_v, r7_v, r8_v;
  fx_t r5_m, r5_a1, r5_b, r5_hh, r5_up, r5_uq;
  fx_t r6_tm, r6_mh, r6_a1, r6_b, r6_hh, r6_up, r6_uq;
  fx_t r7_ta, r7_mh, r7_b, r7_hh, r7_up, r7_uq;
  fx_t r8_theta, r8_mh, r8_b, r8_up, r8_uq;
  fx_t th;
  assign th = tfpf_pkg::sadd(r7_hh, r7_ta);

  always_ff @(posedge clk) begin
    if (rst) begin
      r5_v <= 1'b0;
      r6_v <= 1'b0;
      r7_v <= 1'b0;
      r8_v <= 1'b0;
    end else if (en) begin
      r5_v <= d1_v;
      r6_v <= r5_v;
      r7_v <= r6_v;
      r8_v <= r7_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r5_m  <= tfpf_pkg::sadd(tfpf_pkg::sadd(d1_dz ? '0 : d1_q, d1_t2), d1_t3);
      r5_a1 <= d1_a1;
      r5_b  <= d1_b;
      r5_hh <= d1_hh;
      r5_up <= d1_up;
      r5_uq <= d1_uq;

      r6_tm <= tfpf_pkg::fmul(tau_x, r5_m);
      r6_mh <= tfpf_pkg::fmul(r5_m, h_x);
      r6_a1 <= r5_a1;
      r6_b  <= r5_b;
      r6_hh <= r5_hh;
      r6_up <= r5_up;
      r6_uq <= r5_uq;

      r7_ta <= tfpf_pkg::fmul(r6_tm, r6_a1);
      r7_mh <= r6_mh;
      r7_b  <= r6_b;
      r7_hh <= r6_hh;
      r7_up <= r6_up;
      r7_uq <= r6_uq;

      r8_theta <= (th[31] || th == '0) ? tfpf_pkg::FX_ONE_LSB : th;
      r8_mh    <= r7_mh;
      r8_b     <= r7_b;
      r8_up    <= r7_up;
      r8_uq    <= r7_uq;
    end
  end

  localparam int SIDE2_W = 3 * tfpf_pkg::DATA_WIDTH;
  logic               d2_v;
  fx_t                d2_q;
  logic [SIDE2_W-1:0] d2_side;
  fx_t d2_b, d2_up, d2_uq;

  tfpf_div #(.SIDE_W(SIDE2_W)) u_div_damp (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (r8_v),
    .num      (r8_mh),
    .den      (r8_theta),
    .side_in  ({r8_b, r8_up, r8_uq}),
    .out_valid(d2_v),
    .quo      (d2_q),
    .side_out (d2_side)
  );

  assign {d2_b, d2_up, d2_uq} = d2_side;

  logic r9_v, r10_v;
  fx_t r9_fq, r9_up, r9_uq;
  fx_t r10_tf, r10_up, r10_uq;

  always_ff @(posedge clk) begin
    if (rst) begin
      r9_v  <= 1'b0;
      r10_v <= 1'b0;
    end else if (en) begin
      r9_v  <= d2_v;
      r10_v <= r9_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r9_fq  <= tfpf_pkg::fmul(d2_q, d2_b);
      r9_up  <= d2_up;
      r9_uq  <= d2_uq;
      r10_tf <= tfpf_pkg::fmul(tau_x, tfpf_pkg::sneg(r9_fq));
      r10_up <= r9_up;
      r10_uq <= r9_uq;
    end
  end

  localparam int SIDE3_W = 2 * tfpf_pkg::DATA_WIDTH;
  logic               d3_v;
  fx_t                d3_q;
  logic [SIDE3_W-1:0] d3_side;
  fx_t d3_up, d3_uq;

  tfpf_div #(.SIDE_W(SIDE3_W)) u_div_step (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (r10_v),
    .num      (r10_tf),
    .den      (h_x),
    .side_in  ({r10_up, r10_uq}),
    .out_valid(d3_v),
    .quo      (d3_q),
    .side_out (d3_side)
  );

  assign {d3_up, d3_uq} = d3_side;

  // clamp and update
  fx_t d_lim, d_fin, neg_uq;
  logic signed [32:0] nq_w, np_w;
  logic [30:0] nq_c, np_c;

  always_comb begin
    neg_uq = -d3_uq;
    d_lim  = (d3_q < d3_up) ? d3_q : d3_up;
    d_fin  = (d_lim < neg_uq) ? neg_uq : d_lim;
    nq_w   = 33'(d3_uq) + 33'(d_fin);
    np_w   = 33'(d3_up) - 33'(d_fin);
    if (nq_w[32]) begin
      nq_c = '0;
    end else if (nq_w[31]) begin
      nq_c = '1;
    end else begin
      nq_c = nq_w[30:0];
    end
    if (np_w[32]) begin
      np_c = '0;
    end else if (np_w[31]) begin
      np_c = '1;
    end else begin
      np_c = np_w[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r11_v <= 1'b0;
    end else if (en) begin
      r11_v <= d3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {2'b00, np_c, nq_c, d_fin};
    end
  end

  assign m_tvalid = r11_v;

endmodule
`default_nettype wire

### design/tfpf_chk.sv
`default_nettype none
module tfpf_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [95:0] m_tdata
);

  // output register empty or draining: input side must be open
  a_open: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input blocked while output is free");

  // reset flushes the pipeline
  a_flush: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("stalled item dropped");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata))
    else $error("stalled item changed");

endmodule

bind thin_film_pair_flux tfpf_chk u_tfpf_chk (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
`default_nettype wire
